### rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

  // Width of the payload fields on both channels
  localparam int FIELD_W = 32;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_PICK,
    ST_MUL,
    ST_SQUARE,
    ST_DONE
  } state_t;

endpackage

### rtl/mexp_req_if.sv
// Request channel: base, exponent and modulus with valid/ready.
interface mexp_req_if import mexp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] base_value;
  logic [FIELD_W-1:0] exponent;
  logic [FIELD_W-1:0] modulus;

  modport source (output valid, output base_value, output exponent, output modulus,
                  input ready);
  modport sink (input valid, input base_value, input exponent, input modulus,
                output ready);
endinterface

### rtl/mexp_rsp_if.sv
// Response channel: power result and modulus error flag with valid/ready.
interface mexp_rsp_if import mexp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] power_result;
  logic               modulus_error;

  modport source (output valid, output power_result, output modulus_error, input ready);
  modport sink (input valid, input power_result, input modulus_error, output ready);
endinterface

### rtl/mexp_modmul.sv
// Bit-serial modular multiplier: product = (op_a * op_b) mod modulus, one bit of op_b a cycle.
module mexp_modmul import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  input  logic [WIDTH-1:0] modulus,
  output logic             done,
  output logic [WIDTH-1:0] product
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] mult_a;
  logic [WIDTH-1:0] mult_b;
  logic [WIDTH-1:0] mod;
  logic [CNT_W-1:0] cnt;
  logic             running;

  logic [WIDTH:0]   dbl;
  logic [WIDTH-1:0] dbl_mod;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] sum_mod;
  logic [WIDTH-1:0] acc_next;

  // Double the accumulator mod m, then add op_a mod m when the current bit is set
  always_comb begin
    dbl     = {1'b0, acc} + {1'b0, acc};
    dbl_mod = (dbl >= {1'b0, mod}) ? WIDTH'(dbl - {1'b0, mod}) : dbl[WIDTH-1:0];
    sum     = {1'b0, dbl_mod} + {1'b0, mult_a};
    sum_mod = (sum >= {1'b0, mod}) ? WIDTH'(sum - {1'b0, mod}) : sum[WIDTH-1:0];
    acc_next = mult_b[WIDTH-1] ? sum_mod : dbl_mod;
  end

  // Control: run until the last bit, then pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // Datapath: load operands on start, advance one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mult_a <= op_a;
      mult_b <= op_b;
      mod    <= modulus;
      cnt    <= CNT_W'(WIDTH - 1);
    end else if (running) begin
      acc    <= acc_next;
      mult_b <= {mult_b[WIDTH-2:0], 1'b0};
      cnt    <= cnt - 1'b1;
    end
  end

  assign product = acc;

endmodule

### rtl/modular_exponentiation.sv
// Modular exponentiation: base^exponent mod modulus by right-to-left square and multiply.
//
// Usage:
//   req carries base_value, exponent and modulus; a beat is taken when valid and
//   ready are both high. ready is high only while the block is idle.
//   rsp carries power_result and modulus_error; one beat per request.
//   A zero modulus returns 0 with modulus_error set in the cycle after the request beat.
//   An exponent of zero returns 1, unreduced.
// Sequencing:
//   Each modular product runs through one shared bit-serial multiplier, one bit
//   of the multiplier operand per cycle. The base is reduced first by one such
//   pass. Each exponent bit up to the highest set bit then takes one square, plus
//   one multiply when the bit is set, plus a pass through the dispatch state.
// Flow: one item at a time; the next request beat is taken at the earliest in the
//   cycle after the response beat.
// Reset: rst is synchronous and returns the sequencer to idle; any item in flight
//   is dropped. A stalled rsp holds the result and the block stays not ready.
module modular_exponentiation import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  mexp_req_if.sink   req,
  mexp_rsp_if.source rsp
);

  state_t state;
  state_t state_next;

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] sq;
  logic [WIDTH-1:0] exp_left;
  logic [WIDTH-1:0] mod;
  logic             err;

  logic [WIDTH-1:0] in_base;
  logic [WIDTH-1:0] in_exp;
  logic [WIDTH-1:0] in_mod;
  logic             in_beat;

  logic             mm_start;
  logic [WIDTH-1:0] mm_a;
  logic [WIDTH-1:0] mm_b;
  logic [WIDTH-1:0] mm_m;
  logic             mm_done;
  logic [WIDTH-1:0] mm_prod;

  // Mask inputs to the datapath width
  assign in_base = WIDTH'(req.base_value);
  assign in_exp  = WIDTH'(req.exponent);
  assign in_mod  = WIDTH'(req.modulus);
  assign in_beat = req.valid && req.ready;

  // Shared modular multiplier
  mexp_modmul #(.WIDTH(WIDTH)) u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .op_a    (mm_a),
    .op_b    (mm_b),
    .modulus (mm_m),
    .done    (mm_done),
    .product (mm_prod)
  );

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier dispatch
  always_comb begin
    state_next = state;
    mm_start   = 1'b0;
    mm_a       = sq;
    mm_b       = sq;
    mm_m       = mod;
    req.ready  = 1'b0;
    rsp.valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        mm_a      = WIDTH'(1);
        mm_b      = in_base;
        mm_m      = in_mod;
        if (req.valid) begin
          if (in_mod == '0) begin
            state_next = ST_DONE;
          end else begin
            mm_start   = 1'b1;
            state_next = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (exp_left == '0) begin
          state_next = ST_DONE;
        end else if (exp_left[0]) begin
          mm_start   = 1'b1;
          mm_a       = acc;
          state_next = ST_MUL;
        end else begin
          mm_start   = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          mm_start   = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mm_done) begin
          state_next = ST_PICK;
        end
      end
      ST_DONE: begin
        rsp.valid = 1'b1;
        if (rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Working registers: result, current square, remaining exponent bits
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          acc      <= (in_mod == '0) ? '0 : WIDTH'(1);
          err      <= (in_mod == '0);
          exp_left <= in_exp;
          mod      <= in_mod;
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          sq <= mm_prod;
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          acc <= mm_prod;
        end
      end
      ST_SQUARE: begin
        if (mm_done) begin
          sq       <= mm_prod;
          exp_left <= exp_left >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result beat
  assign rsp.power_result  = FIELD_W'(acc);
  assign rsp.modulus_error = err;

endmodule
